>>> hdl/stli_pkg.sv
`default_nettype none
package stli_pkg;
   localparam int KeyW = 32;
   localparam int ValW = 32;
   localparam int ProdW = 64;

   typedef enum logic [1:0] {
      KIND_CLEAR  = 2'd0,
      KIND_INSERT = 2'd1,
      KIND_QUERY  = 2'd2,
      KIND_NONE   = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2,
      ST_RSVD  = 2'd3
   } status_type;

   typedef struct packed {
      logic [1:0]             kind;
      logic signed [KeyW-1:0] item_key;
      logic signed [ValW-1:0] item_value;
   } req_type;

   typedef struct packed {
      logic signed [ValW-1:0] result_value;
      logic [1:0]             status;
   } rsp_type;

   // per-cell status handed to the sequencer
   typedef struct packed {
      logic                   occupied;
      logic                   le_key;    // key of cell <= probe key
      logic                   eq_key;
      logic signed [KeyW-1:0] key;
      logic signed [ValW-1:0] value;
   } cell_stat_type;
endpackage
`default_nettype wire

>>> hdl/stli_if.sv
`default_nettype none
interface stli_if #(parameter type T = logic) (input wire logic clock);
   logic valid;
   logic ready;
   T     data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> hdl/stli_cell.sv
`default_nettype none
// One table slot. On insert, a slot above the insertion point takes its left
// neighbour's pair (shift right); the slot at the insertion point takes the new pair.
// Slot 0 sees a left neighbour that is always occupied and at or below the probe.
module stli_cell (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                clear,
   input  wire logic                                insert,
   input  wire logic signed [stli_pkg::KeyW-1:0]    probe_key,
   input  wire logic signed [stli_pkg::ValW-1:0]    probe_value,
   input  wire stli_pkg::cell_stat_type             left,
   output stli_pkg::cell_stat_type                  stat
);
   logic                              occ_ff, occ_in;
   logic signed [stli_pkg::KeyW-1:0]  key_ff, key_in;
   logic signed [stli_pkg::ValW-1:0]  val_ff, val_in;
   logic                              moves, takes_new, from_left;

   // slot moves if occupied and its key is above probe; left neighbour then shifts in
   always_comb begin
      from_left = left.occupied && !left.le_key;
      moves     = occ_ff && !stat.le_key;
      takes_new = (!occ_ff || moves) && left.occupied && left.le_key;
      occ_in = occ_ff;
      key_in = key_ff;
      val_in = val_ff;
      if (clear) begin
         occ_in = 1'b0;
      end else if (insert) begin
         if (from_left) begin
            occ_in = 1'b1;
            key_in = left.key;
            val_in = left.value;
         end else if (takes_new) begin
            occ_in = 1'b1;
            key_in = probe_key;
            val_in = probe_value;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= 1'b0;
      end else begin
         occ_ff <= occ_in;
      end
      key_ff <= key_in;
      val_ff <= val_in;
   end

   assign stat.occupied = occ_ff;
   assign stat.le_key   = key_ff <= probe_key;
   assign stat.eq_key   = key_ff == probe_key;
   assign stat.key      = key_ff;
   assign stat.value    = val_ff;
endmodule
`default_nettype wire

>>> hdl/stli_div.sv
`default_nettype none
// Restoring divider, one quotient bit per cycle, 64 by 33 bits.
module stli_div (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [stli_pkg::ProdW-1:0]    dividend,
   input  wire logic [stli_pkg::KeyW:0]       divisor,
   output logic                               done,
   output logic [stli_pkg::ProdW-1:0]         quotient
);
   localparam int CntW = $clog2(stli_pkg::ProdW + 1);
   logic [CntW-1:0]                cnt_ff, cnt_in;
   logic [stli_pkg::KeyW+1:0]      rem_ff, rem_in;
   logic [stli_pkg::ProdW-1:0]     quo_ff, quo_in;
   logic [stli_pkg::KeyW:0]        dsr_ff, dsr_in;
   logic                           busy_ff, busy_in, done_ff, done_in;
   logic [stli_pkg::KeyW+1:0]      trial;

   always_comb begin
      trial   = {rem_ff[stli_pkg::KeyW:0], quo_ff[stli_pkg::ProdW-1]};
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         dsr_in  = divisor;
         cnt_in  = CntW'(stli_pkg::ProdW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dsr_ff}) begin
            rem_in = trial - {1'b0, dsr_ff};
            quo_in = {quo_ff[stli_pkg::ProdW-2:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[stli_pkg::ProdW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CntW'(1);
         if (cnt_ff == CntW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;
endmodule
`default_nettype wire

>>> hdl/sorted_table_linear_interpolator.sv
`default_nettype none
// channel | dir | word
// req     | in  | kind, item_key, item_value
// rsp     | out | result_value, status
// Clear and insert: the result word is registered in the end-check state, S_SCAN.
// Query: S_SCAN does the end checks, S_SRCH the midpoint search, S_LATCH latches the
// neighbours, S_MUL multiplies, S_MUL2 loads the divider, S_DIV waits on the bit-serial
// divider and S_ADD adds; the result word is then shown in S_OUT.
// Reset empties the table at once. One word at a time; a held result blocks req.
module sorted_table_linear_interpolator #(
   parameter int TABLE_DEPTH = 32
) (
   input wire logic clock,
   input wire logic reset,
   stli_if.sink     req,
   stli_if.source   rsp
);
   localparam int IdxW = $clog2(TABLE_DEPTH);
   localparam int CntW = $clog2(TABLE_DEPTH + 1);

   typedef enum logic [8:0] {
      S_IDLE  = 9'b000000001,
      S_SCAN  = 9'b000000010,
      S_SRCH  = 9'b000000100,
      S_LATCH = 9'b000001000,
      S_MUL   = 9'b000010000,
      S_MUL2  = 9'b000100000,
      S_DIV   = 9'b001000000,
      S_ADD   = 9'b010000000,
      S_OUT   = 9'b100000000
   } state_type;

   state_type                  state_ff, state_in;
   stli_pkg::req_type          req_ff;
   stli_pkg::cell_stat_type    stat [TABLE_DEPTH];
   stli_pkg::cell_stat_type    left [TABLE_DEPTH];
   logic                       cell_clear, cell_insert, full, empty;
   logic signed [31:0]         res_ff, res_in, v1_ff;
   logic [32:0]                d_ff;
   logic [31:0]                a_ff, dvm_ff;
   logic                       neg_ff;
   logic [63:0]                prod_ff;
   logic [1:0]                 st_ff, st_in;
   logic                       div_done;
   logic [63:0]                quo;
   logic [CntW-1:0]            count_ff, count_in;
   logic [IdxW-1:0]            lo_ff, lo_in, hi_ff, hi_in, mid, last;
   logic signed [32:0]         a_diff, dv;
   logic [32:0]                d_diff, dv_mag;
   logic signed [33:0]         sum;

   always_comb begin
      left[0] = '0;
      left[0].occupied = 1'b1;
      left[0].le_key   = 1'b1;
      for (int i = 1; i < TABLE_DEPTH; i++) left[i] = stat[i-1];
   end

   for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
      stli_cell u_cell (
         .clock(clock), .reset(reset), .clear(cell_clear), .insert(cell_insert),
         .probe_key(req_ff.item_key), .probe_value(req_ff.item_value),
         .left(left[g]), .stat(stat[g])
      );
   end

   assign full  = stat[TABLE_DEPTH-1].occupied;
   assign empty = !stat[0].occupied;
   assign last  = IdxW'(count_ff - CntW'(1));
   assign mid   = lo_ff + ((hi_ff - lo_ff) >> 1);

   // neighbours once the search has closed: hi below the key, lo above it
   assign a_diff = 33'(req_ff.item_key) - 33'(stat[hi_ff].key);
   assign d_diff = 33'(stat[lo_ff].key) - 33'(stat[hi_ff].key);
   assign dv     = 33'(stat[lo_ff].value) - 33'(stat[hi_ff].value);
   assign dv_mag = dv[32] ? -dv : dv;

   stli_div u_div (
      .clock(clock), .reset(reset), .start(state_ff == S_MUL2),
      .dividend(prod_ff), .divisor(d_ff), .done(div_done), .quotient(quo)
   );

   assign sum = 34'(v1_ff) + (neg_ff ? -34'(signed'(quo[33:0])) : 34'(signed'({1'b0, quo[32:0]})));

   always_comb begin
      state_in    = state_ff;
      cell_clear  = 1'b0;
      cell_insert = 1'b0;
      res_in      = res_ff;
      st_in       = st_ff;
      count_in    = count_ff;
      lo_in       = lo_ff;
      hi_in       = hi_ff;
      unique case (state_ff)
         S_IDLE: if (req.valid) state_in = S_SCAN;
         S_SCAN: begin
            res_in   = '0;
            st_in    = stli_pkg::ST_OK;
            state_in = S_OUT;
            lo_in    = '0;
            hi_in    = last;
            case (stli_pkg::kind_type'(req_ff.kind))
               stli_pkg::KIND_CLEAR: begin
                  cell_clear = 1'b1;
                  count_in   = '0;
               end
               stli_pkg::KIND_INSERT: begin
                  if (full) st_in = stli_pkg::ST_FULL;
                  else begin
                     cell_insert = 1'b1;
                     count_in    = count_ff + CntW'(1);
                  end
               end
               stli_pkg::KIND_QUERY: begin
                  if (empty) st_in = stli_pkg::ST_EMPTY;
                  else if (!stat[0].le_key || stat[0].eq_key) res_in = stat[0].value;
                  else if (stat[last].le_key) res_in = stat[last].value;
                  else state_in = S_SRCH;
               end
               default: ;
            endcase
         end
         // one midpoint step per cycle; closes on the last key below and the first key above the probe
         S_SRCH: begin
            if (lo_ff > hi_ff) begin
               state_in = S_LATCH;
            end else if (stat[mid].eq_key) begin
               res_in   = stat[mid].value;
               state_in = S_OUT;
            end else if (stat[mid].le_key) begin
               lo_in = mid + IdxW'(1);
            end else begin
               hi_in = mid - IdxW'(1);
            end
         end
         S_LATCH: state_in = S_MUL;
         S_MUL:   state_in = S_MUL2;
         S_MUL2:  state_in = S_DIV;
         S_DIV:   if (div_done) state_in = S_ADD;
         S_ADD: begin
            res_in   = sum[31:0];
            state_in = S_OUT;
         end
         S_OUT:   if (rsp.ready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
      if (state_ff == S_IDLE && req.valid) req_ff <= req.data;
      if (state_ff == S_LATCH) begin
         v1_ff  <= stat[hi_ff].value;
         a_ff   <= a_diff[31:0];
         d_ff   <= d_diff;
         dvm_ff <= dv_mag[31:0];
         neg_ff <= dv[32];
      end
      if (state_ff == S_MUL) prod_ff <= 64'(a_ff) * 64'(dvm_ff);
      lo_ff  <= lo_in;
      hi_ff  <= hi_in;
      res_ff <= res_in;
      st_ff  <= st_in;
   end

   assign req.ready = state_ff == S_IDLE;
   assign rsp.valid = state_ff == S_OUT;
   assign rsp.data.result_value = res_ff;
   assign rsp.data.status = st_ff;

   a_one: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> !req.ready) else $error("req taken while result pending");
   a_div: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == S_DIV) else $error("divider done outside divide");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && !rsp.ready) |=> rsp.valid && $stable(res_ff))
      else $error("result dropped");
endmodule
`default_nettype wire

>>> bench/testbench.sv
`default_nettype none
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int Depth = 32;
   localparam int WatchLimit = 4000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   stli_if #(.T(stli_pkg::req_type)) req_ch (.clock(clock));
   stli_if #(.T(stli_pkg::rsp_type)) rsp_ch (.clock(clock));

   sorted_table_linear_interpolator #(.TABLE_DEPTH(Depth)) u_top (
      .clock(clock),
      .reset(reset),
      .req(req_ch.sink),
      .rsp(rsp_ch.source)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // predictor state
   logic signed [31:0] tbl_keys [Depth];
   logic signed [31:0] tbl_vals [Depth];
   int tbl_count = 0;
   stli_pkg::rsp_type expected_words [$];
   int fail_count = 0;
   int idle_cycles = 0;
   bit stall_enable = 1'b1;

   initial begin
      req_ch.valid = 1'b0;
      req_ch.data = '0;
      rsp_ch.ready = 1'b0;
   end

   function automatic logic signed [31:0] interpolate(logic signed [31:0] key);
      int lo;
      int hi;
      int mid;
      longint a;
      longint d;
      longint dv;
      longint unsigned mag;
      longint q;
      if (key <= tbl_keys[0]) return tbl_vals[0];
      if (key >= tbl_keys[tbl_count-1]) return tbl_vals[tbl_count-1];
      lo = 0;
      hi = tbl_count - 1;
      while (lo <= hi) begin
         mid = lo + (hi - lo) / 2;
         if (tbl_keys[mid] == key) return tbl_vals[mid];
         if (tbl_keys[mid] < key) lo = mid + 1;
         else hi = mid - 1;
      end
      a = longint'(key) - longint'(tbl_keys[hi]);
      d = longint'(tbl_keys[lo]) - longint'(tbl_keys[hi]);
      dv = longint'(tbl_vals[lo]) - longint'(tbl_vals[hi]);
      mag = longint'(a) * (dv < 0 ? -dv : dv);
      q = longint'(mag / longint'(d));
      if (dv < 0) q = -q;
      return 32'(longint'(tbl_vals[hi]) + q);
   endfunction

   function automatic stli_pkg::rsp_type table_step(stli_pkg::req_type w);
      stli_pkg::rsp_type r;
      int pos;
      r = '0;
      r.status = stli_pkg::ST_OK;
      case (stli_pkg::kind_type'(w.kind))
         stli_pkg::KIND_CLEAR: tbl_count = 0;
         stli_pkg::KIND_INSERT: begin
            if (tbl_count >= Depth) begin
               r.status = stli_pkg::ST_FULL;
            end else begin
               pos = 0;
               while (pos < tbl_count && tbl_keys[pos] <= w.item_key) pos++;
               for (int i = tbl_count; i > pos; i--) begin
                  tbl_keys[i] = tbl_keys[i-1];
                  tbl_vals[i] = tbl_vals[i-1];
               end
               tbl_keys[pos] = w.item_key;
               tbl_vals[pos] = w.item_value;
               tbl_count++;
            end
         end
         stli_pkg::KIND_QUERY: begin
            if (tbl_count == 0) r.status = stli_pkg::ST_EMPTY;
            else r.result_value = interpolate(w.item_key);
         end
         default: ;
      endcase
      return r;
   endfunction

   task automatic report(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
      fail_count++;
   endtask

   // valid stays high between back-to-back words; it drops only for a gap
   task automatic send_word(stli_pkg::kind_type k, logic [31:0] key, logic [31:0] val);
      stli_pkg::req_type w;
      w.kind = k;
      w.item_key = key;
      w.item_value = val;
      if (stall_enable && $urandom_range(0, 5) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.data <= w;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      expected_words.push_back(table_step(w));
   endtask

   // result side: random stalls while stall_enable is set, compare against oldest expectation
   always @(posedge clock) begin
      stli_pkg::rsp_type want;
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_words.size() == 0) begin
               report("unexpected word", rsp_ch.data.result_value, 0);
            end else begin
               want = expected_words.pop_front();
               if (rsp_ch.data.result_value !== want.result_value)
                  report("result_value", rsp_ch.data.result_value, want.result_value);
               if (rsp_ch.data.status !== want.status)
                  report("status", 32'(rsp_ch.data.status), 32'(want.status));
            end
         end
         if (!stall_enable) rsp_ch.ready <= 1'b1;
         else if (idle_cycles > 0) begin
            idle_cycles <= idle_cycles - 1;
            rsp_ch.ready <= 1'b0;
         end else if ($urandom_range(0, 5) == 0) begin
            idle_cycles <= $urandom_range(0, 3);
            rsp_ch.ready <= 1'b0;
         end else rsp_ch.ready <= 1'b1;
      end
   end

   // watchdog on cycles with no accepted word
   int quiet_cycles = 0;
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         quiet_cycles <= 0;
      else if (!reset) quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WatchLimit) begin
         $display("testbench: FAIL");
         $finish;
      end
   end

   function automatic logic [31:0] rand_word();
      case ($urandom_range(0, 4))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return $urandom_range(0, 8) << 16;
         default: return $urandom;
      endcase
   endfunction

   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (expected_words.size() != 0);
   endtask

   task automatic test_directed();
      send_word(stli_pkg::KIND_QUERY, 32'h0, 32'h0);            // empty table
      send_word(stli_pkg::KIND_NONE, 32'hffff_ffff, 32'hffff_ffff);
      send_word(stli_pkg::KIND_INSERT, 32'h8000_0000, 32'h7fff_ffff);
      send_word(stli_pkg::KIND_INSERT, 32'h7fff_ffff, 32'h8000_0000);
      send_word(stli_pkg::KIND_QUERY, 32'h0, 32'h0);            // widest span
      send_word(stli_pkg::KIND_QUERY, 32'h8000_0000, 32'h0);
      send_word(stli_pkg::KIND_QUERY, 32'h7fff_ffff, 32'h0);
      send_word(stli_pkg::KIND_INSERT, 32'h0001_0000, 32'h0005_0000);
      send_word(stli_pkg::KIND_INSERT, 32'h0001_0000, 32'h0009_0000); // equal key
      send_word(stli_pkg::KIND_QUERY, 32'h0001_0000, 32'h0);
      send_word(stli_pkg::KIND_QUERY, 32'hffff_0000, 32'h0);
      send_word(stli_pkg::KIND_CLEAR, 32'hffff_ffff, 32'hffff_ffff);
      send_word(stli_pkg::KIND_INSERT, 32'h0002_0000, 32'h0003_0000);
      send_word(stli_pkg::KIND_QUERY, 32'h0000_0000, 32'h0);    // single entry
      send_word(stli_pkg::KIND_QUERY, 32'h0005_0000, 32'h0);
      for (int i = 0; i < Depth; i++)
         send_word(stli_pkg::KIND_INSERT, 32'(i) << 16, $urandom);
      send_word(stli_pkg::KIND_QUERY, 32'h0004_8000, 32'h0);
      send_word(stli_pkg::KIND_CLEAR, 32'h0, 32'h0);
   endtask

   // fill to a random size, then mostly queries; sometimes past full
   task automatic test_random_tables();
      int n;
      int spread;
      for (int t = 0; t < 55; t++) begin
         if (t == 40) stall_enable = 1'b0;
         n = ($urandom_range(0, 5) == 0) ? Depth + 2 : $urandom_range(1, 12);
         spread = $urandom_range(0, 3);
         send_word(stli_pkg::KIND_CLEAR, $urandom, $urandom);
         for (int i = 0; i < n; i++)
            send_word(stli_pkg::KIND_INSERT, spread == 0 ? rand_word() :
                      32'($signed($urandom_range(0, 16 * spread)) - 8) << 16,
                      rand_word());
         for (int i = 0; i < 18; i++)
            send_word($urandom_range(0, 30) == 0 ? stli_pkg::KIND_NONE :
                      stli_pkg::KIND_QUERY,
                      spread == 0 ? rand_word() :
                      32'($signed($urandom_range(0, 1 << (20 + spread))) -
                          (1 << 19)) << 0, $urandom);
         if (t == 20) wait_drained();
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random_tables();
      wait_drained();
      repeat (100) @(posedge clock);
      if (fail_count == 0 && expected_words.size() == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end
endmodule
`default_nettype wire
